FILE: hw/rtl/fsa_pkg.sv
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared types, widths and codes of the frame stack averager.
// ----------------------------------------------------------------------------
package fsa_pkg;

    localparam int PIXEL_COUNT_W = 17;
    localparam int IMAGE_COUNT_W = 9;
    localparam int PORT_SAMPLE_W = 8;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;

    localparam int MAX_PIXELS_DEF  = 65536;
    localparam int SAMPLE_BITS_DEF = 8;
    localparam int SUM_BITS_DEF    = 16;

    localparam logic [PIXEL_COUNT_W-1:0] PIXEL_COUNT_RST = 17'd65536;
    localparam logic [IMAGE_COUNT_W-1:0] IMAGE_COUNT_RST = 9'd1;

    // register index, taken from paddr[2]
    localparam logic REG_PIXEL_COUNT = 1'b0;
    localparam logic REG_IMAGE_COUNT = 1'b1;

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic [PIXEL_COUNT_W-1:0] pixel_count;
        logic [IMAGE_COUNT_W-1:0] image_count;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC,
        ST_FETCH,
        ST_DIV
    } t_state;

endpackage

FILE: hw/rtl/fsa_ram.sv
// ----------------------------------------------------------------------------
// fsa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fsa_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 65536
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/fsa_apb.sv
// ----------------------------------------------------------------------------
// fsa_apb
// APB register file: pixel_count at 0x0, image_count at 0x4.
// ----------------------------------------------------------------------------
module fsa_apb (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fsa_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [fsa_pkg::APB_DATA_W-1:0] pwdata,
    output logic [fsa_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    output fsa_pkg::t_cfg                 o_cfg
);
    import fsa_pkg::*;

    logic [PIXEL_COUNT_W-1:0] r_pixel_count;
    logic [IMAGE_COUNT_W-1:0] r_image_count;
    logic                     wr;

    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count <= PIXEL_COUNT_RST;
            r_image_count <= IMAGE_COUNT_RST;
        end else if (wr) begin
            case (paddr[2])
                REG_PIXEL_COUNT: r_pixel_count <= pwdata[PIXEL_COUNT_W-1:0];
                REG_IMAGE_COUNT: r_image_count <= pwdata[IMAGE_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_PIXEL_COUNT: prdata = APB_DATA_W'(r_pixel_count);
            REG_IMAGE_COUNT: prdata = APB_DATA_W'(r_image_count);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.pixel_count = r_pixel_count;
    assign o_cfg.image_count = r_image_count;

endmodule

FILE: hw/rtl/fsa_divider.sv
// ----------------------------------------------------------------------------
// fsa_divider
// Three-lane restoring divider, one quotient bit per lane per cycle.
// ----------------------------------------------------------------------------
module fsa_divider #(
    parameter int SUM_BITS = fsa_pkg::SUM_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [3*SUM_BITS-1:0]              i_dividend,
    input  logic [fsa_pkg::IMAGE_COUNT_W-1:0]  i_divisor,
    output fsa_pkg::t_div_stat                 o_stat,
    output logic [3*SUM_BITS-1:0]              o_quotient
);
    import fsa_pkg::*;

    localparam int DW = IMAGE_COUNT_W;
    localparam int CW = $clog2(SUM_BITS + 1);

    logic [DW-1:0]       r_div;
    logic [DW-1:0]       r_rem [3];
    logic [SUM_BITS-1:0] r_quo [3];
    logic [CW-1:0]       r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [DW:0]   trial [3];
    logic          ge    [3];
    logic [DW:0]   diff  [3];

    // remainder stays below the divisor, so it fits in DW bits
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            trial[c] = {r_rem[c], r_quo[c][SUM_BITS-1]};
            ge[c]    = trial[c] >= {1'b0, r_div};
            diff[c]  = trial[c] - {1'b0, r_div};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(SUM_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            for (int c = 0; c < 3; c++) begin
                r_rem[c] <= '0;
                r_quo[c] <= i_dividend[c*SUM_BITS +: SUM_BITS];
            end
        end else if (r_busy) begin
            for (int c = 0; c < 3; c++) begin
                r_rem[c] <= ge[c] ? diff[c][DW-1:0] : trial[c][DW-1:0];
                r_quo[c] <= {r_quo[c][SUM_BITS-2:0], ge[c]};
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = {r_quo[2], r_quo[1], r_quo[0]};

endmodule

FILE: hw/rtl/frame_stack_averager_core.sv
// ----------------------------------------------------------------------------
// frame_stack_averager_core
// Temporal averaging of RGB frames over a per-pixel sum memory.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   input    | i_valid / o_ready    | i_op, i_red_in, i_green_in, i_blue_in
//   output   | o_valid / i_ready    | o_red_avg, o_green_avg, o_blue_avg,
//            |                      | o_last_pixel
//   config   | psel/penable/pready  | paddr, pwdata, prdata
//
// Accumulate: memory read, then saturating add and write back.
// Read: memory read, then bit-serial division, then the output register.
// After reset a clearing pass zeroes the sum memory with o_ready low;
// configuration writes are taken during it.
// A stalled output holds in its register; the next item is still accepted.
// ----------------------------------------------------------------------------
module frame_stack_averager_core #(
    parameter int MAX_PIXELS  = fsa_pkg::MAX_PIXELS_DEF,
    parameter int SAMPLE_BITS = fsa_pkg::SAMPLE_BITS_DEF,
    parameter int SUM_BITS    = fsa_pkg::SUM_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_op,
    input  logic [fsa_pkg::PORT_SAMPLE_W-1:0] i_red_in,
    input  logic [fsa_pkg::PORT_SAMPLE_W-1:0] i_green_in,
    input  logic [fsa_pkg::PORT_SAMPLE_W-1:0] i_blue_in,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [fsa_pkg::PORT_SAMPLE_W-1:0] o_red_avg,
    output logic [fsa_pkg::PORT_SAMPLE_W-1:0] o_green_avg,
    output logic [fsa_pkg::PORT_SAMPLE_W-1:0] o_blue_avg,
    output logic                              o_last_pixel,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fsa_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [fsa_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [fsa_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import fsa_pkg::*;

    localparam int PW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int MW    = $clog2(MAX_PIXELS + 1);
    localparam int CNTW  = (MW > PIXEL_COUNT_W) ? MW : PIXEL_COUNT_W;
    localparam int XW0   = (SUM_BITS > SAMPLE_BITS) ? SUM_BITS : SAMPLE_BITS;
    localparam int XW    = (XW0 > PORT_SAMPLE_W) ? XW0 : PORT_SAMPLE_W;
    localparam int AW    = XW + 1;
    localparam int WIDTH = 3 * SUM_BITS;

    localparam logic [CNTW-1:0] MAX_CNT    = CNTW'(MAX_PIXELS);
    localparam logic [XW-1:0]   SAMPLE_MAX = XW'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [AW-1:0]   SUM_MAX    = AW'((64'd1 << SUM_BITS) - 64'd1);

    t_cfg      cfg;
    t_div_stat div_stat;
    t_state    r_state, n_state;

    logic [PW-1:0]       r_clr;
    logic [PW-1:0]       r_wr_pos, r_rd_pos, r_addr;
    logic [PORT_SAMPLE_W-1:0] r_smp [3];
    logic                r_last;
    logic                r_out_valid;
    logic [PORT_SAMPLE_W-1:0] r_avg [3];
    logic                r_out_last;

    logic [CNTW-1:0]  pc_x, count;
    logic [PW-1:0]    pos_sel, pos_eff, pos_next;
    logic [CNTW-1:0]  pos_inc;
    logic             in_accept, out_load;
    logic             ram_we, ram_re;
    logic [PW-1:0]    ram_waddr;
    logic [WIDTH-1:0] ram_wdata, ram_rdata, acc_data;
    logic             div_start;
    logic [WIDTH-1:0] quotient;
    logic [IMAGE_COUNT_W-1:0] divisor;

    fsa_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fsa_ram #(
        .WIDTH (WIDTH),
        .DEPTH (MAX_PIXELS)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (pos_eff),
        .o_rdata (ram_rdata)
    );

    fsa_divider #(
        .SUM_BITS (SUM_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (ram_rdata),
        .i_divisor  (divisor),
        .o_stat     (div_stat),
        .o_quotient (quotient)
    );

    // effective frame size and divisor
    assign pc_x    = CNTW'(cfg.pixel_count);
    assign count   = (pc_x == '0) ? CNTW'(1) : ((pc_x > MAX_CNT) ? MAX_CNT : pc_x);
    assign divisor = (cfg.image_count == '0) ? IMAGE_COUNT_W'(1) : cfg.image_count;

    // position wraps when it lies beyond a shrunken frame
    assign pos_sel  = (i_op == OP_READ) ? r_rd_pos : r_wr_pos;
    assign pos_eff  = (CNTW'(pos_sel) >= count) ? '0 : pos_sel;
    assign pos_inc  = CNTW'(pos_eff) + CNTW'(1);
    assign pos_next = (pos_inc >= count) ? '0 : pos_inc[PW-1:0];

    assign o_ready   = (r_state == ST_IDLE);
    assign in_accept = i_valid & o_ready;
    assign ram_re    = in_accept;
    assign out_load  = (r_state == ST_DIV) && div_stat.done && (!r_out_valid || i_ready);

    // saturating accumulate of the fetched sums
    always_comb begin
        logic [XW-1:0] smp_x;
        logic [AW-1:0] sum_a;
        acc_data = '0;
        for (int c = 0; c < 3; c++) begin
            smp_x = XW'(r_smp[c]) & SAMPLE_MAX;
            sum_a = AW'(ram_rdata[c*SUM_BITS +: SUM_BITS]) + AW'(smp_x);
            acc_data[c*SUM_BITS +: SUM_BITS] =
                (sum_a > SUM_MAX) ? SUM_MAX[SUM_BITS-1:0] : sum_a[SUM_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = acc_data;
        div_start = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                if (r_clr == PW'(MAX_PIXELS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = (i_op == OP_READ) ? ST_FETCH : ST_ACC;
                end
            end
            ST_ACC: begin
                ram_we  = 1'b1;
                n_state = ST_IDLE;
            end
            ST_FETCH: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_wr_pos    <= '0;
            r_rd_pos    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (in_accept) begin
                if (i_op == OP_READ) begin
                    r_rd_pos <= pos_next;
                end else begin
                    r_wr_pos <= pos_next;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // transaction payload and result capture
    always_ff @(posedge i_clk) begin
        logic [XW-1:0] q_x;
        if (in_accept) begin
            r_addr   <= pos_eff;
            r_smp[0] <= i_red_in;
            r_smp[1] <= i_green_in;
            r_smp[2] <= i_blue_in;
            r_last   <= (CNTW'(pos_eff) == count - CNTW'(1));
        end
        if (out_load) begin
            for (int c = 0; c < 3; c++) begin
                q_x = XW'(quotient[c*SUM_BITS +: SUM_BITS]);
                if (q_x > SAMPLE_MAX) begin
                    q_x = SAMPLE_MAX;
                end
                r_avg[c] <= q_x[PORT_SAMPLE_W-1:0];
            end
            r_out_last <= r_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_red_avg    = r_avg[0];
    assign o_green_avg  = r_avg[1];
    assign o_blue_avg   = r_avg[2];
    assign o_last_pixel = r_out_last;

    // memory writes never overlap an accepted transaction
    a_we_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !in_accept)
        else $error("sum memory written while a transaction is accepted");

    a_acc_writes_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_op == OP_ACCUM) |=> ram_we)
        else $error("accumulate not written back in the following cycle");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_out_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_DIV && div_stat.done))
        else $error("result shown without a finished division");

endmodule
